[hw/rtl/psd_pkg.sv]
// Shared types and constants for the port scan detector.
package psd_pkg;

  localparam int unsigned PairEntriesDef  = 64;
  localparam int unsigned PortsPerPairDef = 32;
  localparam int unsigned QueueDepth      = 2;

  localparam logic [15:0] EtherIpv4   = 16'h0800;
  localparam logic [3:0]  IpVersion4  = 4'd4;
  localparam logic [7:0]  ProtoTcp    = 8'd6;
  localparam logic [5:0]  LimitReset  = 6'd20;
  localparam logic [15:0] WindowReset = 16'd5000;
  localparam logic [7:0]  LimitFloor  = 8'd2;

  // configuration register indexes
  localparam logic CfgPortLimit = 1'b0;
  localparam logic CfgWindowMs  = 1'b1;

  typedef enum logic [2:0] {
    OUT_IGNORED = 3'd0,
    OUT_NEW     = 3'd1,
    OUT_UPDATED = 3'd2,
    OUT_FULL    = 3'd3,
    OUT_SCAN    = 3'd4
  } outcome_e;

  // one queued packet header
  typedef struct packed {
    logic        ignore;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] port;
    logic [31:0] now;
  } pkt_t;

endpackage

[hw/rtl/psd_ram.sv]
// Generic single-port RAM with registered read.
module psd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[hw/rtl/psd_front.sv]
// Front end: accepts headers, classifies them and queues them for the engine.
module psd_front import psd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] ether_kind_i,
  input  logic [3:0]  ip_version_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic [31:0] source_addr_i,
  input  logic [31:0] dest_addr_i,
  input  logic [15:0] dest_port_i,
  input  logic [31:0] time_ms_i,
  input  logic        pop_i,
  output logic        q_valid_o,
  output pkt_t        q_item_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  pkt_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q;
  logic            push;
  pkt_t            item;

  // classify: only IPv4 TCP takes part in tracking
  always_comb begin
    item.ignore = (ether_kind_i != EtherIpv4) || (ip_version_i != IpVersion4) ||
                  (ip_protocol_i != ProtoTcp);
    item.src    = source_addr_i;
    item.dst    = dest_addr_i;
    item.port   = dest_port_i;
    item.now    = time_ms_i;
  end

  assign busy      = (cnt_q == (PtrW+1)'(QueueDepth));
  assign push      = start && !busy;
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop_i);
    end
  end

endmodule

[hw/rtl/psd_back.sv]
// Back end: pair table search, port set update and result generation.
module psd_back import psd_pkg::*; #(
  parameter int unsigned PAIR_ENTRIES   = PairEntriesDef,
  parameter int unsigned PORTS_PER_PAIR = PortsPerPairDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [5:0]  port_limit_i,
  input  logic [15:0] window_ms_i,
  input  logic        q_valid_i,
  input  pkt_t        q_item_i,
  output logic        pop_o,
  output logic        done_o,
  output logic [2:0]  outcome_o,
  output logic        scan_alert_o,
  output logic [31:0] alert_source_o
);

  localparam int unsigned AW = (PAIR_ENTRIES > 1) ? $clog2(PAIR_ENTRIES) : 1;
  localparam int unsigned PW = $clog2(PORTS_PER_PAIR);
  localparam int unsigned CW = $clog2(PORTS_PER_PAIR + 1);
  localparam int unsigned MW = 32 + 1 + CW;
  localparam int unsigned PD = (2 ** AW) * (2 ** PW);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAIR  = 6'b000010,
    S_NEW   = 6'b000100,
    S_META  = 6'b001000,
    S_MDATA = 6'b010000,
    S_PORT  = 6'b100000
  } state_e;

  state_e         state_q, state_d;
  pkt_t           pkt_q, pkt_d;
  logic [AW:0]    fill_q, fill_d, idx_q, idx_d;
  logic [AW-1:0]  cmp_q, cmp_d, hit_q, hit_d;
  logic           dv_q, dv_d;
  logic [CW-1:0]  n_q, n_d, k_q, k_d;
  logic           fin_q, fin_d;
  logic           present_q, present_d;
  logic           done_d;
  logic [2:0]     outcome_d;

  logic           pair_we, meta_we, port_we;
  logic [AW-1:0]  pair_addr, meta_addr;
  logic [AW+PW-1:0] port_addr;
  logic [63:0]    pair_rdata;
  logic [MW-1:0]  meta_wdata, meta_rdata;
  logic [15:0]    port_rdata;
  logic [AW-1:0]  fill_lo;
  logic [7:0]     lim_raw, lim_eff;
  logic [CW-1:0]  n_new, m_count;
  logic [31:0]    m_last;
  logic           m_fresh, expired, add;

  assign fill_lo = fill_q[AW-1:0];
  assign m_last  = meta_rdata[MW-1 -: 32];
  assign m_fresh = meta_rdata[CW];
  assign m_count = meta_rdata[CW-1:0];
  assign expired = !m_fresh || ((pkt_q.now - m_last) >= {16'd0, window_ms_i});

  // effective limit saturated into the range from 2 to the store size
  assign lim_raw = {2'b00, port_limit_i};
  assign lim_eff = (lim_raw < LimitFloor) ? LimitFloor :
                   (lim_raw > 8'(PORTS_PER_PAIR)) ? 8'(PORTS_PER_PAIR) : lim_raw;

  assign add   = !present_q && (n_q < CW'(PORTS_PER_PAIR));
  assign n_new = add ? n_q + 1'b1 : n_q;

  psd_ram #(.Width(64), .Depth(2 ** AW)) u_pair_ram (
    .clk_i  (clk_i),
    .we_i   (pair_we),
    .addr_i (pair_addr),
    .wdata_i({pkt_q.src, pkt_q.dst}),
    .rdata_o(pair_rdata)
  );

  psd_ram #(.Width(MW), .Depth(2 ** AW)) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .addr_i (meta_addr),
    .wdata_i(meta_wdata),
    .rdata_o(meta_rdata)
  );

  psd_ram #(.Width(16), .Depth(PD)) u_port_ram (
    .clk_i  (clk_i),
    .we_i   (port_we),
    .addr_i (port_addr),
    .wdata_i(pkt_q.port),
    .rdata_o(port_rdata)
  );

  // engine sequencer
  always_comb begin
    state_d    = state_q;
    pkt_d      = pkt_q;
    fill_d     = fill_q;
    idx_d      = idx_q;
    cmp_d      = cmp_q;
    hit_d      = hit_q;
    dv_d       = dv_q;
    n_d        = n_q;
    k_d        = k_q;
    fin_d      = 1'b0;
    present_d  = present_q;
    done_d     = 1'b0;
    outcome_d  = OUT_IGNORED;
    pop_o      = 1'b0;
    pair_we    = 1'b0;
    meta_we    = 1'b0;
    port_we    = 1'b0;
    pair_addr  = idx_q[AW-1:0];
    meta_addr  = hit_q;
    port_addr  = {hit_q, k_q[PW-1:0]};
    meta_wdata = {pkt_q.now, 1'b1, CW'(1)};

    // final update of a known pair, in the cycle after the port scan ends
    if (fin_q) begin
      port_addr = {hit_q, n_q[PW-1:0]};
      port_we   = add;
      meta_we   = 1'b1;
      done_d    = 1'b1;
      if (8'(n_new) >= lim_eff) begin
        meta_wdata = {pkt_q.now, 1'b0, CW'(0)};
        outcome_d  = OUT_SCAN;
      end else begin
        meta_wdata = {pkt_q.now, 1'b1, n_new};
        outcome_d  = OUT_UPDATED;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (q_valid_i && !fin_q) begin
          pop_o = 1'b1;
          pkt_d = q_item_i;
          if (q_item_i.ignore) begin
            done_d    = 1'b1;
            outcome_d = OUT_IGNORED;
          end else begin
            idx_d   = '0;
            dv_d    = 1'b0;
            state_d = S_PAIR;
          end
        end
      end
      S_PAIR: begin
        if (dv_q && (pair_rdata == {pkt_q.src, pkt_q.dst})) begin
          hit_d   = cmp_q;
          state_d = S_META;
        end else if (idx_q < fill_q) begin
          dv_d  = 1'b1;
          cmp_d = idx_q[AW-1:0];
          idx_d = idx_q + 1'b1;
        end else begin
          state_d = S_NEW;
        end
      end
      S_NEW: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (fill_q == (AW+1)'(PAIR_ENTRIES)) begin
          outcome_d = OUT_FULL;
        end else begin
          outcome_d = OUT_NEW;
          pair_addr = fill_lo;
          meta_addr = fill_lo;
          port_addr = {fill_lo, PW'(0)};
          pair_we   = 1'b1;
          meta_we   = 1'b1;
          port_we   = 1'b1;
          fill_d    = fill_q + 1'b1;
        end
      end
      S_META: begin
        state_d = S_MDATA;
      end
      S_MDATA: begin
        n_d       = expired ? '0 : m_count;
        k_d       = '0;
        dv_d      = 1'b0;
        present_d = 1'b0;
        state_d   = S_PORT;
      end
      S_PORT: begin
        if (dv_q && (port_rdata == pkt_q.port)) begin
          present_d = 1'b1;
          fin_d     = 1'b1;
          state_d   = S_IDLE;
        end else if (k_q < n_q) begin
          dv_d = 1'b1;
          k_d  = k_q + 1'b1;
        end else begin
          fin_d   = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    pkt_q     <= pkt_d;
    idx_q     <= idx_d;
    cmp_q     <= cmp_d;
    hit_q     <= hit_d;
    n_q       <= n_d;
    k_q       <= k_d;
    present_q <= present_d;
    outcome_o      <= outcome_d;
    scan_alert_o   <= (outcome_d == OUT_SCAN);
    alert_source_o <= (outcome_d == OUT_SCAN) ? pkt_q.src : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      dv_q    <= 1'b0;
      fin_q   <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      dv_q    <= dv_d;
      fin_q   <= fin_d;
      done_o  <= done_d;
    end
  end

endmodule

[hw/rtl/port_scan_detector.sv]
// Top level of the port scan detector: config registers, front end and engine.
// The engine takes one packet at a time and walks the single-port table RAMs one
//   entry per cycle; a 2-deep queue takes packets meanwhile.
// Reset clears the queue, the pair fill count and the config registers to
//   port_limit 20 and window_ms 5000. Results cannot be stalled by the receiver.
module port_scan_detector import psd_pkg::*; #(
  parameter int unsigned PAIR_ENTRIES   = PairEntriesDef,
  parameter int unsigned PORTS_PER_PAIR = PortsPerPairDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] ether_kind_i,
  input  logic [3:0]  ip_version_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic [31:0] source_addr_i,
  input  logic [31:0] dest_addr_i,
  input  logic [15:0] dest_port_i,
  input  logic [31:0] time_ms_i,
  output logic        done_o,
  output logic [2:0]  outcome_o,
  output logic        scan_alert_o,
  output logic [31:0] alert_source_o
);

  logic [5:0]  port_limit_q;
  logic [15:0] window_ms_q;
  logic        q_valid, pop;
  pkt_t        q_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_limit_q <= LimitReset;
      window_ms_q  <= WindowReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgPortLimit: port_limit_q <= cfg_wdata_i[5:0];
        CfgWindowMs:  window_ms_q  <= cfg_wdata_i;
        default:      port_limit_q <= port_limit_q;
      endcase
    end
  end

  psd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .ether_kind_i (ether_kind_i),
    .ip_version_i (ip_version_i),
    .ip_protocol_i(ip_protocol_i),
    .source_addr_i(source_addr_i),
    .dest_addr_i  (dest_addr_i),
    .dest_port_i  (dest_port_i),
    .time_ms_i    (time_ms_i),
    .pop_i        (pop),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item)
  );

  psd_back #(
    .PAIR_ENTRIES  (PAIR_ENTRIES),
    .PORTS_PER_PAIR(PORTS_PER_PAIR)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .port_limit_i  (port_limit_q),
    .window_ms_i   (window_ms_q),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .pop_o         (pop),
    .done_o        (done_o),
    .outcome_o     (outcome_o),
    .scan_alert_o  (scan_alert_o),
    .alert_source_o(alert_source_o)
  );

  // checks
  a_alert_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (scan_alert_o == (outcome_o == OUT_SCAN)))
    else $error("alert flag disagrees with outcome");

  a_alert_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !scan_alert_o) |-> (alert_source_o == 32'd0))
    else $error("alert source without alert");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the port scan detector.
`timescale 1ns / 100ps

module tb;
  import psd_pkg::*;

  localparam int unsigned Entries = PairEntriesDef;
  localparam int unsigned Ports   = PortsPerPairDef;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_addr_i;
  logic [15:0] cfg_wdata_i;
  logic        start;
  logic        busy;
  logic [15:0] ether_kind_i;
  logic [3:0]  ip_version_i;
  logic [7:0]  ip_protocol_i;
  logic [31:0] source_addr_i;
  logic [31:0] dest_addr_i;
  logic [15:0] dest_port_i;
  logic [31:0] time_ms_i;
  logic        done_o;
  logic [2:0]  outcome_o;
  logic        scan_alert_o;
  logic [31:0] alert_source_o;

  port_scan_detector dut (.*);

  typedef struct {
    logic [15:0] ether;
    logic [3:0]  ver;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] port;
    logic [31:0] now;
  } header_t;

  typedef struct {
    outcome_e    outcome;
    logic        alert;
    logic [31:0] alert_src;
  } verdict_t;

  // shadow of the detector's pair table and registers
  logic [5:0]  limit_reg;
  logic [15:0] window_reg;
  logic        tr_valid  [Entries];
  logic [31:0] tr_src    [Entries];
  logic [31:0] tr_dst    [Entries];
  logic [31:0] tr_seen   [Entries];
  logic        tr_fresh  [Entries];
  int          tr_count  [Entries];
  logic [15:0] tr_ports  [Entries][Ports];

  verdict_t verdict_q[$];
  int errors, n_sent, n_checked, n_scans, n_full, n_ignored;
  int sender_idle;
  logic [31:0] clock_ms;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %0s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // classify one header and update the shadow table
  function automatic verdict_t classify_packet(header_t h);
    verdict_t v;
    int hit, free_slot, n, lim;
    logic present;
    hit = -1;
    free_slot = -1;
    v.outcome = OUT_IGNORED;
    v.alert = 1'b0;
    v.alert_src = '0;
    if (h.ether != EtherIpv4 || h.ver != IpVersion4 || h.proto != ProtoTcp) return v;
    for (int i = 0; i < Entries; i++) begin
      if (tr_valid[i]) begin
        if (hit < 0 && tr_src[i] == h.src && tr_dst[i] == h.dst) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit < 0) begin
      if (free_slot < 0) begin
        v.outcome = OUT_FULL;
        return v;
      end
      tr_valid[free_slot] = 1'b1;
      tr_src[free_slot] = h.src;
      tr_dst[free_slot] = h.dst;
      tr_seen[free_slot] = h.now;
      tr_fresh[free_slot] = 1'b1;
      tr_ports[free_slot][0] = h.port;
      tr_count[free_slot] = 1;
      v.outcome = OUT_NEW;
      return v;
    end
    if (!tr_fresh[hit] || (h.now - tr_seen[hit]) >= {16'd0, window_reg}) tr_count[hit] = 0;
    n = tr_count[hit];
    present = 1'b0;
    for (int k = 0; k < n; k++) if (tr_ports[hit][k] == h.port) present = 1'b1;
    if (!present && n < Ports) begin
      tr_ports[hit][n] = h.port;
      n++;
    end
    tr_count[hit] = n;
    tr_seen[hit] = h.now;
    tr_fresh[hit] = 1'b1;
    lim = limit_reg;
    if (lim < 2) lim = 2;
    if (lim > Ports) lim = Ports;
    if (n >= lim) begin
      tr_count[hit] = 0;
      tr_fresh[hit] = 1'b0;
      v.outcome = OUT_SCAN;
      v.alert = 1'b1;
      v.alert_src = h.src;
    end else begin
      v.outcome = OUT_UPDATED;
    end
    return v;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && done_o) begin
      if (verdict_q.size() == 0) begin
        report("unexpected result", {29'd0, outcome_o}, 32'd0);
      end else begin
        want = verdict_q.pop_front();
        n_checked++;
        if (outcome_o != want.outcome)
          report("outcome", {29'd0, outcome_o}, {29'd0, want.outcome});
        if (scan_alert_o != want.alert)
          report("scan_alert", {31'd0, scan_alert_o}, {31'd0, want.alert});
        if (alert_source_o != want.alert_src)
          report("alert_source", alert_source_o, want.alert_src);
        if (want.outcome == OUT_SCAN) n_scans++;
        if (want.outcome == OUT_FULL) n_full++;
        if (want.outcome == OUT_IGNORED) n_ignored++;
      end
    end
  end

  task automatic write_reg(input logic addr, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= data;
    if (addr == CfgPortLimit) limit_reg = data[5:0];
    else window_reg = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every result is back, then for the block's tail latency
  task automatic drain();
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  // send one header; start is held low across idle gaps only
  task automatic send_header(input header_t h);
    if (sender_idle > 0) begin
      while ($urandom_range(99) < sender_idle) begin
        start <= 1'b0;
        @(negedge clk_i);
      end
    end
    start <= 1'b1;
    ether_kind_i <= h.ether;
    ip_version_i <= h.ver;
    ip_protocol_i <= h.proto;
    source_addr_i <= h.src;
    dest_addr_i <= h.dst;
    dest_port_i <= h.port;
    time_ms_i <= h.now;
    do @(posedge clk_i); while (busy);
    verdict_q.push_back(classify_packet(h));
    n_sent++;
    @(negedge clk_i);
  endtask

  function automatic header_t tcp_header(logic [31:0] src, logic [31:0] dst,
                                         logic [15:0] port, logic [31:0] now);
    header_t h;
    h.ether = EtherIpv4;
    h.ver = IpVersion4;
    h.proto = ProtoTcp;
    h.src = src;
    h.dst = dst;
    h.port = port;
    h.now = now;
    return h;
  endfunction

  // random header: mostly scans over a small set of pairs, some noise
  function automatic header_t random_header(int n_pairs);
    header_t h;
    int sel;
    sel = $urandom_range(99);
    h = tcp_header({8'($urandom_range(3)), 8'd0, 8'd0, 8'($urandom_range(n_pairs - 1))},
                   {$urandom_range(1) ? 32'hffff_ffff : 32'h0a00_0001},
                   16'($urandom_range(40)), clock_ms);
    if (sel < 5) h.port = 16'($urandom);
    if (sel < 2) h.src = $urandom;
    if (sel >= 5 && sel < 9) h.ether = 16'($urandom);
    if (sel >= 9 && sel < 12) h.ver = 4'($urandom);
    if (sel >= 12 && sel < 15) h.proto = 8'($urandom);
    if (sel >= 15 && sel < 18) h.dst = $urandom;
    clock_ms += $urandom_range(3) == 0 ? $urandom_range(8000) : $urandom_range(40);
    if ($urandom_range(199) == 0) clock_ms = $urandom;
    return h;
  endfunction

  // directed stimulus: header plus optional typed-in outcome
  typedef struct {
    header_t  h;
    logic     known;
    outcome_e want;
  } step_t;

  step_t directed[$];

  function automatic step_t row(header_t h, logic known, outcome_e want);
    step_t s;
    s.h = h;
    s.known = known;
    s.want = want;
    return s;
  endfunction

  initial begin
    header_t h;
    verdict_t got;
    int phase_items;
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_scans = 0;
    n_full = 0;
    n_ignored = 0;
    sender_idle = 0;
    clock_ms = 32'd100;
    limit_reg = LimitReset;
    window_reg = WindowReset;
    foreach (tr_valid[i]) tr_valid[i] = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = CfgPortLimit;
    cfg_wdata_i = '0;
    start = 1'b0;
    ether_kind_i = '0;
    ip_version_i = '0;
    ip_protocol_i = '0;
    source_addr_i = '0;
    dest_addr_i = '0;
    dest_port_i = '0;
    time_ms_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (3) @(negedge clk_i);

    // directed: non-IP, wrong version, non-TCP, extremes, window and limit cases
    h = tcp_header(32'hffff_ffff, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
    directed.push_back(row(h, 1'b1, OUT_NEW));
    h.ether = 16'hffff;
    directed.push_back(row(h, 1'b1, OUT_IGNORED));
    h = tcp_header(32'h0, 32'h0, 16'h0, 32'h0);
    h.ver = 4'hf;
    directed.push_back(row(h, 1'b1, OUT_IGNORED));
    h.ver = IpVersion4;
    h.proto = 8'hff;
    directed.push_back(row(h, 1'b1, OUT_IGNORED));
    directed.push_back(row(tcp_header(32'h0, 32'h0, 16'h0, 32'h0), 1'b1, OUT_NEW));
    // same port again, then time wrap inside the window
    directed.push_back(row(tcp_header(32'h0, 32'h0, 16'h0, 32'h10), 1'b1, OUT_UPDATED));
    directed.push_back(row(tcp_header(32'hffff_ffff, 32'hffff_ffff, 16'h1, 32'h5), 1'b1,
                           OUT_UPDATED));
    // gap exactly the window restarts the set
    directed.push_back(row(tcp_header(32'h0, 32'h0, 16'h1, 32'h10 + 32'd5000), 1'b0,
                           OUT_IGNORED));
    for (int p = 2; p < 20; p++)
      directed.push_back(row(tcp_header(32'h0, 32'h0, 16'(p), 32'd5100 + p), 1'b0,
                             OUT_IGNORED));
    foreach (directed[i]) begin
      send_header(directed[i].h);
      got = verdict_q[$];
      if (directed[i].known && got.outcome != directed[i].want)
        report("directed row", {29'd0, got.outcome}, {29'd0, directed[i].want});
    end
    start <= 1'b0;
    drain();

    // limit and window extremes, then random settings: limit 0 saturates to 2, 63 to the store size
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_reg(CfgPortLimit, 16'd0);
        1: write_reg(CfgPortLimit, 16'd63);
        2: write_reg(CfgWindowMs, 16'd0);
        3: write_reg(CfgWindowMs, 16'hffff);
        4: write_reg(CfgPortLimit, 16'd2);
        5: write_reg(CfgPortLimit, 16'd32);
        6: write_reg(CfgWindowMs, 16'd1);
        default: begin
          write_reg(CfgPortLimit, 16'($urandom_range(2, 12)));
          write_reg(CfgWindowMs, 16'($urandom_range(50, 20000)));
        end
      endcase
      sender_idle = (ph % 4 == 1) ? 56 : (ph % 4 == 2) ? 35 : 0;
      phase_items = (ph == 7) ? 400 : 230;
      for (int n = 0; n < phase_items; n++) begin
        send_header(random_header(ph < 4 ? 8 : 90));
        // hold off until the detector has answered everything
        if (n == phase_items / 2) begin
          start <= 1'b0;
          while (verdict_q.size() != 0) @(negedge clk_i);
        end
      end
      start <= 1'b0;
      drain();
    end

    $display("sent %0d headers, checked %0d results: %0d scans, %0d drops on full table",
             n_sent, n_checked, n_scans, n_full);
    $display("%0d ignored; limits 0..63 and windows 0..65535 exercised, with and without gaps",
             n_ignored);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
